@@ hw/rtl/trapezoid_step_period_generator_assert.svh @@
// Assertion macros for the step period generator.
// Needs a signal named clock and a signal named reset in the including scope.
`ifndef TRAPEZOID_STEP_PERIOD_GENERATOR_ASSERT_SVH
`define TRAPEZOID_STEP_PERIOD_GENERATOR_ASSERT_SVH

// same-cycle implication
`define TSPG_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/tspg_pkg.sv @@
// Shared types and constants of the step period generator.
// No dependencies.
`default_nettype none

package tspg_pkg;

   localparam int unsigned SPEED_W     = 24;
   localparam int unsigned COUNT_W     = 24;
   localparam int unsigned PERIOD_W    = 20;
   localparam int unsigned ENTRIES_MAX = 16;
   localparam int unsigned SLOT_W      = 4;
   localparam int unsigned LEN_W       = 5;
   localparam int unsigned DIV_W       = 64;
   localparam int unsigned TICK_HZ     = 1000000;
   localparam int unsigned FREQ_SCALE  = 80;

   typedef enum logic [0:0] {
      CSR_AXIS_ENABLE = 1'b0,
      CSR_ENTRIES     = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

@@ hw/rtl/tspg_if.sv @@
// Valid/ready channel interfaces: segment words, period words, register writes.
// Depends on tspg_pkg.
`default_nettype none

interface tspg_req_if;
   logic                                valid;
   logic                                ready;
   logic [tspg_pkg::SPEED_W-1:0]        start_speed;
   logic [tspg_pkg::SPEED_W-1:0]        stop_speed;
   logic [tspg_pkg::SPEED_W-1:0]        peak_speed;
   logic [tspg_pkg::SPEED_W-1:0]        accel_rate;
   logic [tspg_pkg::COUNT_W-1:0]        count_x;
   logic [tspg_pkg::COUNT_W-1:0]        count_y;
   logic [tspg_pkg::COUNT_W-1:0]        count_z;
   logic [tspg_pkg::COUNT_W-1:0]        count_e;
   modport source (output valid, start_speed, stop_speed, peak_speed, accel_rate,
                   count_x, count_y, count_z, count_e, input ready);
   modport sink   (input valid, start_speed, stop_speed, peak_speed, accel_rate,
                   count_x, count_y, count_z, count_e, output ready);
endinterface

interface tspg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          axis_id;
   logic [tspg_pkg::SLOT_W-1:0]         slot;
   logic [tspg_pkg::PERIOD_W-1:0]       period_us;
   logic                                axis_done;
   logic                                last;
   modport source (output valid, axis_id, slot, period_us, axis_done, last, input ready);
   modport sink   (input valid, axis_id, slot, period_us, axis_done, last, output ready);
endinterface

interface tspg_csr_if;
   logic                                valid;
   logic                                ready;
   tspg_pkg::csr_index_type             index;
   logic [tspg_pkg::LEN_W-1:0]          data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/trapezoid_step_period_generator.sv @@
// Trapezoidal step period generator, top level.
// Depends on tspg_pkg, tspg_if.sv and trapezoid_step_period_generator_assert.svh.
//
// Usage:
//  req: one segment word (speeds, accel, four axis step counts). ready is high
//       only while the block is idle; one segment is worked at a time.
//  rsp: period words, axis by axis (x, y, z, e), up to entries_per_axis (max 16)
//       per axis; axis_done marks an axis's final word, last the segment's final.
//  csr: register writes, always ready; write only while idle.
// Sharing: one restoring divider and one 26x24 multiplier are shared
//  under the sequencer. A cruise period is worked out once and reused for
//  each further cruise word.
// A finished word waits in a hold register, then moves to the output register;
//  if rsp stalls the sequencer holds at the next word until the output frees.
// Reset (synchronous) returns to idle, drops pending words, and sets
//  axis_enable to 15 and entries_per_axis to 16.
`default_nettype none

module trapezoid_step_period_generator (
   input  wire logic   clock,
   input  wire logic   reset,
   tspg_req_if.sink    req,
   tspg_rsp_if.source  rsp,
   tspg_csr_if.sink    csr
);

   `include "trapezoid_step_period_generator_assert.svh"

   localparam int unsigned SW = tspg_pkg::SPEED_W;
   localparam int unsigned CW = tspg_pkg::COUNT_W;
   localparam int unsigned DW = tspg_pkg::DIV_W;
   localparam int unsigned PW = tspg_pkg::PERIOD_W;
   localparam int unsigned LW = tspg_pkg::LEN_W;

   typedef enum logic [27:0] {
      ST_IDLE   = 28'h0000001,
      ST_TOT    = 28'h0000002,
      ST_SQP    = 28'h0000004,
      ST_SQE    = 28'h0000008,
      ST_RDIV   = 28'h0000010,
      ST_RDONE  = 28'h0000020,
      ST_CLAMP  = 28'h0000040,
      ST_LEN    = 28'h0000080,
      ST_AXIS   = 28'h0000100,
      ST_FIRST  = 28'h0000200,
      ST_FIRST2 = 28'h0000400,
      ST_FIRST3 = 28'h0000800,
      ST_ACHK   = 28'h0001000,
      ST_ADIV   = 28'h0002000,
      ST_AV     = 28'h0004000,
      ST_F1     = 28'h0008000,
      ST_F2     = 28'h0010000,
      ST_F3     = 28'h0020000,
      ST_PUT    = 28'h0040000,
      ST_CRU    = 28'h0080000,
      ST_CCHK   = 28'h0100000,
      ST_DCHK   = 28'h0200000,
      ST_DDIV   = 28'h0400000,
      ST_DV     = 28'h0800000,
      ST_AXEND  = 28'h1000000,
      ST_NEXTAX = 28'h2000000,
      ST_FLUSH  = 28'h4000000,
      ST_DIV    = 28'h8000000
   } state_type;

   typedef enum logic [2:0] {
      PH_ACC = 3'b001,
      PH_CRU = 3'b010,
      PH_DEC = 3'b100
   } phase_type;

   state_type         state_ff, state_in, ret_ff, ret_in;
   phase_type         phase_ff, phase_in;
   logic              rsel_ff, rsel_in;
   logic [SW-1:0]     ent_ff, ent_in, ext_ff, ext_in, pk_ff, pk_in, acc_ff, acc_in;
   logic [CW-1:0]     cnt_ff [4];
   logic [CW-1:0]     cnt_in [4];
   logic [CW-1:0]     tot_ff, tot_in, sc_ff, sc_in, i_ff, i_in;
   logic [39:0]       sa_ff, sa_in, sd_ff, sd_in;
   logic [LW-1:0]     len_ff, len_in, idx_ff, idx_in;
   logic [1:0]        ax_ff, ax_in;
   logic [PW-1:0]     per_ff, per_in;
   logic [47:0]       ps_ff, ps_in;
   logic [49:0]       prod_ff;
   logic [DW-1:0]     num_ff, num_in, den_ff, den_in, rem_ff, rem_in;
   logic [6:0]        dcnt_ff, dcnt_in;
   logic              hold_v_ff, hold_v_in, hold_done_ff, hold_done_in;
   logic [1:0]        hold_ax_ff, hold_ax_in;
   logic [3:0]        hold_slot_ff, hold_slot_in;
   logic [PW-1:0]     hold_per_ff, hold_per_in;
   logic              rsp_v_ff, rsp_v_in, rsp_done_ff, rsp_done_in, rsp_last_ff, rsp_last_in;
   logic [1:0]        rsp_ax_ff, rsp_ax_in;
   logic [3:0]        rsp_slot_ff, rsp_slot_in;
   logic [PW-1:0]     rsp_per_ff, rsp_per_in;
   logic [3:0]        ae_ff, ae_in;
   logic [LW-1:0]     epa_ff, epa_in;

   logic [25:0]       mul_a;
   logic [CW-1:0]     mul_b;
   logic [CW-1:0]     s_cur, tot_max, m01, m23;
   logic [DW:0]       rem_sh;
   logic              rem_ge, rsp_free;
   logic [55:0]       f_scaled;

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid     = rsp_v_ff;
   assign rsp.axis_id   = rsp_ax_ff;
   assign rsp.slot      = rsp_slot_ff;
   assign rsp.period_us = rsp_per_ff;
   assign rsp.axis_done = rsp_done_ff;
   assign rsp.last      = rsp_last_ff;

   assign s_cur    = cnt_ff[ax_ff];
   assign m01      = (cnt_ff[0] > cnt_ff[1]) ? cnt_ff[0] : cnt_ff[1];
   assign m23      = (cnt_ff[2] > cnt_ff[3]) ? cnt_ff[2] : cnt_ff[3];
   assign tot_max  = (m01 > m23) ? m01 : m23;
   assign rem_sh   = {rem_ff, num_ff[DW-1]};
   assign rem_ge   = rem_sh >= {1'b0, den_ff};
   assign rsp_free = !rsp_v_ff || rsp.ready;
   assign f_scaled = 56'(prod_ff) * 56'(tspg_pkg::FREQ_SCALE);

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;  phase_in = phase_ff;  rsel_in = rsel_ff;
      ent_in = ent_ff;  ext_in = ext_ff;  pk_in = pk_ff;  acc_in = acc_ff;
      cnt_in = cnt_ff;  tot_in = tot_ff;  sc_in = sc_ff;  i_in = i_ff;
      sa_in = sa_ff;  sd_in = sd_ff;  len_in = len_ff;  idx_in = idx_ff;  ax_in = ax_ff;
      per_in = per_ff;  ps_in = ps_ff;
      num_in = num_ff;  den_in = den_ff;  rem_in = rem_ff;  dcnt_in = dcnt_ff;
      hold_v_in = hold_v_ff;  hold_done_in = hold_done_ff;  hold_ax_in = hold_ax_ff;
      hold_slot_in = hold_slot_ff;  hold_per_in = hold_per_ff;
      rsp_v_in = rsp_v_ff && !rsp.ready;
      rsp_done_in = rsp_done_ff;  rsp_last_in = rsp_last_ff;  rsp_ax_in = rsp_ax_ff;
      rsp_slot_in = rsp_slot_ff;  rsp_per_in = rsp_per_ff;
      ae_in = ae_ff;  epa_in = epa_ff;
      mul_a = '0;
      mul_b = '0;

      if (csr.valid) begin
         unique case (csr.index)
            tspg_pkg::CSR_AXIS_ENABLE: ae_in  = csr.data[3:0];
            tspg_pkg::CSR_ENTRIES:     epa_in = csr.data;
            default: ;
         endcase
      end

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req.valid) begin
               ent_in = req.start_speed;  ext_in = req.stop_speed;
               pk_in = req.peak_speed;    acc_in = req.accel_rate;
               cnt_in[0] = req.count_x;   cnt_in[1] = req.count_y;
               cnt_in[2] = req.count_z;   cnt_in[3] = req.count_e;
               state_in = ST_TOT;
            end
         end
         ST_TOT: begin
            tot_in  = tot_max;
            rsel_in = 1'b0;
            state_in = (tot_max == '0) ? ST_IDLE : ST_SQP;
         end
         ST_SQP: begin
            mul_a = 26'(pk_ff);  mul_b = pk_ff;
            state_in = ST_SQE;
         end
         ST_SQE: begin
            ps_in = prod_ff[47:0];
            mul_a = 26'(rsel_ff ? ext_ff : ent_ff);
            mul_b = rsel_ff ? ext_ff : ent_ff;
            state_in = ST_RDIV;
         end
         ST_RDIV: begin
            if (acc_ff == '0 || ps_ff <= prod_ff[47:0]) begin
               if (rsel_ff) begin
                  sd_in = '0;  state_in = ST_CLAMP;
               end else begin
                  sa_in = '0;  rsel_in = 1'b1;  state_in = ST_SQP;
               end
            end else begin
               num_in = DW'(ps_ff - prod_ff[47:0]);
               den_in = DW'({acc_ff, 9'b0});
               rem_in = '0;  dcnt_in = 7'(DW);
               ret_in = ST_RDONE;  state_in = ST_DIV;
            end
         end
         ST_RDONE: begin
            if (rsel_ff) begin
               sd_in = num_ff[39:0];  state_in = ST_CLAMP;
            end else begin
               sa_in = num_ff[39:0];  rsel_in = 1'b1;  state_in = ST_SQP;
            end
         end
         ST_CLAMP: begin
            if (acc_ff == '0 || ({1'b0, sa_ff} + {1'b0, sd_ff}) > 41'(tot_ff)) begin
               sa_in = 40'(tot_ff >> 1);
               sd_in = 40'(tot_ff >> 1);
            end
            state_in = ST_LEN;
         end
         ST_LEN: begin
            sc_in  = tot_ff - sa_ff[CW-1:0] - sd_ff[CW-1:0];
            len_in = (epa_ff > LW'(tspg_pkg::ENTRIES_MAX)) ?
                     LW'(tspg_pkg::ENTRIES_MAX) : epa_ff;
            ax_in  = '0;
            state_in = ST_AXIS;
         end
         ST_AXIS: begin
            if (ae_ff[ax_ff] && s_cur != '0 && len_ff != '0) begin
               idx_in = '0;
               num_in = DW'({tot_ff, 8'b0}) + DW'(s_cur) * DW'(tspg_pkg::FREQ_SCALE)
                        - DW'(1);
               den_in = DW'(s_cur) * DW'(tspg_pkg::FREQ_SCALE);
               rem_in = '0;  dcnt_in = 7'(DW);
               ret_in = ST_FIRST;  state_in = ST_DIV;
            end else begin
               state_in = ST_NEXTAX;
            end
         end
         ST_FIRST: begin
            if (DW'(ent_ff) >= num_ff) begin
               i_in = '0;  state_in = ST_ACHK;
            end else if (acc_ff == '0) begin
               i_in = sa_ff[CW-1:0];  state_in = ST_ACHK;
            end else begin
               mul_a = 26'(num_ff - DW'(ent_ff));
               mul_b = tot_ff;
               state_in = ST_FIRST2;
            end
         end
         ST_FIRST2: begin
            num_in = DW'(prod_ff) + DW'(acc_ff) - DW'(1);
            den_in = DW'(acc_ff);
            rem_in = '0;  dcnt_in = 7'(DW);
            ret_in = ST_FIRST3;  state_in = ST_DIV;
         end
         ST_FIRST3: begin
            i_in = (num_ff >= DW'(sa_ff)) ? sa_ff[CW-1:0] : num_ff[CW-1:0];
            state_in = ST_ACHK;
         end
         ST_ACHK: begin
            phase_in = PH_ACC;
            if (40'(i_ff) < sa_ff && idx_ff < len_ff) begin
               mul_a = 26'(acc_ff);  mul_b = i_ff;
               state_in = ST_ADIV;
            end else begin
               state_in = ST_CRU;
            end
         end
         ST_ADIV, ST_DDIV: begin
            num_in = DW'(prod_ff);
            den_in = DW'(tot_ff);
            rem_in = '0;  dcnt_in = 7'(DW);
            ret_in = (state_ff == ST_ADIV) ? ST_AV : ST_DV;
            state_in = ST_DIV;
         end
         ST_AV: begin
            mul_a = 26'(ent_ff) + 26'(num_ff[CW-1:0]);
            mul_b = s_cur;
            state_in = ST_F1;
         end
         ST_F1: begin
            num_in = DW'(f_scaled[55:8]);
            den_in = DW'(tot_ff);
            rem_in = '0;  dcnt_in = 7'(DW);
            ret_in = ST_F2;  state_in = ST_DIV;
         end
         ST_F2: begin
            if (num_ff == '0) begin
               case (phase_ff)
                  PH_ACC: begin
                     i_in = i_ff + 1'b1;  state_in = ST_ACHK;
                  end
                  PH_CRU: begin
                     i_in = '0;  phase_in = PH_DEC;  state_in = ST_DCHK;
                  end
                  default: state_in = ST_AXEND;
               endcase
            end else begin
               num_in = DW'(tspg_pkg::TICK_HZ);
               den_in = num_ff;
               rem_in = '0;  dcnt_in = 7'(DW);
               ret_in = ST_F3;  state_in = ST_DIV;
            end
         end
         ST_F3: begin
            per_in = (num_ff == '0) ? PW'(1) : num_ff[PW-1:0];
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (!hold_v_ff || rsp_free) begin
               if (hold_v_ff) begin
                  rsp_v_in = 1'b1;  rsp_ax_in = hold_ax_ff;  rsp_slot_in = hold_slot_ff;
                  rsp_per_in = hold_per_ff;  rsp_done_in = hold_done_ff;
                  rsp_last_in = 1'b0;
               end
               hold_v_in = 1'b1;  hold_ax_in = ax_ff;  hold_slot_in = idx_ff[3:0];
               hold_per_in = per_ff;  hold_done_in = 1'b0;
               idx_in = idx_ff + 1'b1;
               i_in = i_ff + 1'b1;
               case (phase_ff)
                  PH_ACC:  state_in = ST_ACHK;
                  PH_CRU:  state_in = ST_CCHK;
                  default: state_in = ST_DCHK;
               endcase
            end
         end
         ST_CRU: begin
            phase_in = PH_CRU;
            i_in = '0;
            if (sc_ff != '0 && idx_ff < len_ff) begin
               mul_a = 26'(pk_ff);  mul_b = s_cur;
               state_in = ST_F1;
            end else begin
               phase_in = PH_DEC;  state_in = ST_DCHK;
            end
         end
         ST_CCHK: begin
            if (i_ff < sc_ff && idx_ff < len_ff) begin
               state_in = ST_PUT;
            end else begin
               i_in = '0;  phase_in = PH_DEC;  state_in = ST_DCHK;
            end
         end
         ST_DCHK: begin
            if (40'(i_ff) < sd_ff && idx_ff < len_ff) begin
               mul_a = 26'(acc_ff);  mul_b = i_ff;
               state_in = ST_DDIV;
            end else begin
               state_in = ST_AXEND;
            end
         end
         ST_DV: begin
            if (num_ff > DW'(pk_ff)) begin
               state_in = ST_AXEND;
            end else begin
               mul_a = 26'(pk_ff - num_ff[CW-1:0]);
               mul_b = s_cur;
               state_in = ST_F1;
            end
         end
         ST_AXEND: begin
            if (hold_v_ff) hold_done_in = 1'b1;
            state_in = ST_NEXTAX;
         end
         ST_NEXTAX: begin
            if (ax_ff == 2'd3) begin
               state_in = ST_FLUSH;
            end else begin
               ax_in = ax_ff + 1'b1;  state_in = ST_AXIS;
            end
         end
         ST_FLUSH: begin
            if (!hold_v_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_v_in = 1'b1;  rsp_ax_in = hold_ax_ff;  rsp_slot_in = hold_slot_ff;
               rsp_per_in = hold_per_ff;  rsp_done_in = hold_done_ff;
               rsp_last_in = 1'b1;
               hold_v_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
            num_in  = {num_ff[DW-2:0], rem_ge};
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == 7'd1) state_in = ret_ff;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         hold_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         ae_ff     <= 4'hF;
         epa_ff    <= LW'(tspg_pkg::ENTRIES_MAX);
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         hold_v_ff <= hold_v_in;
         rsp_v_ff  <= rsp_v_in;
         ae_ff     <= ae_in;
         epa_ff    <= epa_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;  phase_ff <= phase_in;  rsel_ff <= rsel_in;
      ent_ff <= ent_in;  ext_ff <= ext_in;  pk_ff <= pk_in;  acc_ff <= acc_in;
      cnt_ff <= cnt_in;  tot_ff <= tot_in;  sc_ff <= sc_in;  i_ff <= i_in;
      sa_ff <= sa_in;  sd_ff <= sd_in;  len_ff <= len_in;
      ax_ff <= ax_in;  per_ff <= per_in;  ps_ff <= ps_in;
      prod_ff <= 50'(mul_a) * 50'(mul_b);
      num_ff <= num_in;  den_ff <= den_in;  rem_ff <= rem_in;  dcnt_ff <= dcnt_in;
      hold_done_ff <= hold_done_in;  hold_ax_ff <= hold_ax_in;
      hold_slot_ff <= hold_slot_in;  hold_per_ff <= hold_per_in;
      rsp_done_ff <= rsp_done_in;  rsp_last_ff <= rsp_last_in;  rsp_ax_ff <= rsp_ax_in;
      rsp_slot_ff <= rsp_slot_in;  rsp_per_ff <= rsp_per_in;
   end

   `TSPG_ASSERT_IMPL(a_idle_no_hold, state_ff == ST_IDLE, !hold_v_ff,
                     "word left pending in idle")
   `TSPG_ASSERT_IMPL(a_idx_bound, state_ff != ST_IDLE,
                     idx_ff <= LW'(tspg_pkg::ENTRIES_MAX), "slot index overrun")
   `TSPG_ASSERT_NEXT(a_accept_start, req.valid && req.ready, state_ff == ST_TOT,
                     "segment accept did not start work")

endmodule

`default_nettype wire
